>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, masked during reset
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// next-cycle implication, masked during reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// next-cycle implication, also checked across reset
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

>>> sv/isq_pkg.sv
// Types and codes for the indexed sequence store.
// No dependencies; used by the cell row, the top level, the checkers and the testbench.
package isq_pkg;

   localparam int POS_W   = 7;
   localparam int DATA_W  = 8;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 7;
   localparam int GROUP   = 8;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_WRITE
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_FOLD
   } fsm_state_type;

endpackage

>>> sv/isq_cell.sv
// One cell of the shifting element row: holds one byte, shifts with its neighbors.
// Depends on isq_pkg.
module isq_cell #(
   parameter int INDEX = 0,
   parameter int XW    = 7
) (
   input  logic                         clock,
   input  isq_pkg::cell_cmd_type        cmd,
   input  logic [XW-1:0]                pos,
   input  logic [isq_pkg::DATA_W-1:0]   left_data,
   input  logic [isq_pkg::DATA_W-1:0]   right_data,
   output logic [isq_pkg::DATA_W-1:0]   data,
   output logic [isq_pkg::DATA_W-1:0]   tap
);
   import isq_pkg::*;

   localparam logic [XW-1:0] IDX = XW'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              at_pos;
   logic              past_pos;

   assign at_pos   = (pos == IDX);
   assign past_pos = (IDX > pos);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (past_pos) data_in = left_data;
            else if (at_pos) data_in = cmd.value;
         end
         CELL_DELETE: begin
            if (past_pos || at_pos) data_in = right_data;
         end
         CELL_WRITE: begin
            if (at_pos) data_in = cmd.value;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign tap  = at_pos ? data_ff : '0;

endmodule

>>> sv/indexed_sequence_store.sv
// Top level of the indexed sequence store: control, count and the cell row.
// Depends on isq_pkg and isq_cell.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid/req_stall, mode position value | in
//   result  | rsp_valid/rsp_stall, read_value status   | out
//           | element_count                           |
//
// A word passes through accept, the cell row update with the read taps
// registered in groups of eight, then the group fold into the result register.
// A new request word is taken while a finished result still waits.
// Reset clears the count, the control state and the result valid; cell
// contents are undefined until written. A stalled result holds the pipe in
// the fold step.
module indexed_sequence_store #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [isq_pkg::MODE_W-1:0]    req_mode,
   input  logic [isq_pkg::POS_W-1:0]     req_position,
   input  logic [isq_pkg::DATA_W-1:0]    req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [isq_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [isq_pkg::STAT_W-1:0]    rsp_status,
   output logic [isq_pkg::COUNT_W-1:0]   rsp_element_count
);
   import isq_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam int NG = (CAPACITY + GROUP - 1) / GROUP;

   fsm_state_type     state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [MODE_W-1:0] mode_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] value_ff;

   logic [STAT_W-1:0] stat_ff, stat_in;
   logic              is_read_ff, is_read_in;

   logic [DATA_W-1:0] rd_ff, rd_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic [DATA_W-1:0] part_ff [NG];
   logic [DATA_W-1:0] part_in [NG];

   logic              accept;
   logic              rsp_take;
   logic              load_rsp;
   logic [XW-1:0]     pos_x;
   logic [XW-1:0]     cnt_x;
   logic [XW-1:0]     cnt_next_x;
   logic [DATA_W-1:0] fold;
   cell_cmd_type      cmd;

   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] taps      [NG*GROUP];

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign pos_x    = XW'(pos_ff);
   assign cnt_x    = XW'(count_ff);

   // request decode and control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      stat_in     = stat_ff;
      is_read_in  = is_read_ff;
      cmd.op      = CELL_HOLD;
      cmd.value   = value_ff;
      req_stall   = (state_ff != FSM_IDLE);
      load_rsp    = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            stat_in    = STAT_DONE;
            is_read_in = (mode_ff == MODE_READ);
            case (mode_ff)
               MODE_INSERT: begin
                  if (pos_x > cnt_x) stat_in = STAT_RANGE;
                  else if (count_ff == CW'(CAPACITY)) stat_in = STAT_FULL;
                  else begin
                     cmd.op   = CELL_INSERT;
                     count_in = CW'(count_ff + 1'b1);
                  end
               end
               MODE_DELETE: begin
                  if (pos_x >= cnt_x) stat_in = STAT_RANGE;
                  else begin
                     cmd.op   = CELL_DELETE;
                     count_in = CW'(count_ff - 1'b1);
                  end
               end
               MODE_READ: begin
                  if (pos_x >= cnt_x) stat_in = STAT_RANGE;
               end
               MODE_WRITE: begin
                  if (pos_x >= cnt_x) stat_in = STAT_RANGE;
                  else cmd.op = CELL_WRITE;
               end
               MODE_CLEAR: count_in = '0;
               default: stat_in = STAT_DONE;
            endcase
            state_in = FSM_FOLD;
         end
         FSM_FOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      stat_ff     <= stat_in;
      is_read_ff  <= is_read_in;
      rd_ff       <= rd_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   // cell row
   genvar k;
   generate
      for (k = 0; k < CAPACITY; k++) begin : g_cell
         logic [DATA_W-1:0] left_d;
         logic [DATA_W-1:0] right_d;
         if (k == 0) begin : g_first
            assign left_d = '0;
         end else begin : g_mid_l
            assign left_d = cell_data[k-1];
         end
         if (k == CAPACITY - 1) begin : g_last
            assign right_d = '0;
         end else begin : g_mid_r
            assign right_d = cell_data[k+1];
         end
         isq_cell #(
            .INDEX (k),
            .XW    (XW)
         ) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .pos        (pos_x),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[k]),
            .tap        (taps[k])
         );
      end
      for (k = CAPACITY; k < NG*GROUP; k++) begin : g_pad
         assign taps[k] = '0;
      end
   endgenerate

   // read taps: registered groups, then fold
   genvar g;
   generate
      for (g = 0; g < NG; g++) begin : g_grp
         always_comb begin
            part_in[g] = '0;
            for (int j = 0; j < GROUP; j++) begin
               part_in[g] = part_in[g] | taps[g*GROUP + j];
            end
         end
         always_ff @(posedge clock) begin
            part_ff[g] <= part_in[g];
         end
      end
   endgenerate

   always_comb begin
      fold = '0;
      for (int i = 0; i < NG; i++) begin
         fold = fold | part_ff[i];
      end
   end

   // result register
   assign cnt_next_x = XW'(count_ff);

   always_comb begin
      rd_in        = rd_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      if (load_rsp) begin
         rd_in        = (is_read_ff && stat_ff == STAT_DONE) ? fold : '0;
         rsp_stat_in  = stat_ff;
         rsp_cnt_in   = cnt_next_x[COUNT_W-1:0];
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rd_ff;
   assign rsp_status        = rsp_stat_ff;
   assign rsp_element_count = rsp_cnt_ff;

endmodule

>>> sv/isq_checker.sv
// Port-level checks for the indexed sequence store, bound to the top level.
// Depends on assert_macros.svh and isq_pkg.
`include "assert_macros.svh"

module isq_checker #(
   parameter int CAPACITY = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [isq_pkg::DATA_W-1:0]    rsp_read_value,
   input logic [isq_pkg::STAT_W-1:0]    rsp_status,
   input logic [isq_pkg::COUNT_W-1:0]   rsp_element_count
);
   import isq_pkg::*;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CAPACITY);

   logic                                rsp_err;
   logic                                rsp_full;
   logic [DATA_W+STAT_W+COUNT_W-1:0]    rsp_word;

   assign rsp_err  = rsp_valid && (rsp_status != STAT_DONE);
   assign rsp_full = rsp_valid && (rsp_status == STAT_FULL);
   assign rsp_word = {rsp_read_value, rsp_status, rsp_element_count};

   `ASSERT_NEXT_ALWAYS(a_reset_no_rsp, clock, reset, !rsp_valid)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_IMPLY(a_error_reads_zero, clock, reset, rsp_err, rsp_read_value == '0)
   `ASSERT_IMPLY(a_full_at_capacity, clock, reset, rsp_full, rsp_element_count == FULL_COUNT)
   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

endmodule

bind indexed_sequence_store isq_checker #(.CAPACITY(CAPACITY)) u_isq_checker (.*);

>>> sim/sequence_checker.sv
`timescale 1ns / 100ps
// Result checker for the indexed sequence store: watches both channels,
// predicts each result from its own cell row copy and compares field by field.
// Depends on isq_pkg.
module sequence_checker #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [isq_pkg::MODE_W-1:0]    req_mode,
   input  logic [isq_pkg::POS_W-1:0]     req_position,
   input  logic [isq_pkg::DATA_W-1:0]    req_value,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [isq_pkg::DATA_W-1:0]    rsp_read_value,
   input  logic [isq_pkg::STAT_W-1:0]    rsp_status,
   input  logic [isq_pkg::COUNT_W-1:0]   rsp_element_count,
   output int                            fail_count,
   output int                            pending
);
   import isq_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]   read_value;
      logic [STAT_W-1:0]   status;
      logic [COUNT_W-1:0]  element_count;
   } outcome_type;

   logic [DATA_W-1:0] cells [CAPACITY];
   int                held;
   outcome_type       awaited [$];

   function automatic outcome_type apply_request(input logic [MODE_W-1:0] m,
                                                 input logic [POS_W-1:0] p,
                                                 input logic [DATA_W-1:0] v);
      outcome_type r;
      int          k;
      r = '0;
      r.status = STAT_DONE;
      case (m)
         MODE_INSERT: begin
            if (p > held)
               r.status = STAT_RANGE;
            else if (held >= CAPACITY)
               r.status = STAT_FULL;
            else begin
               for (k = held; k > p; k--)
                  cells[k] = cells[k-1];
               cells[p] = v;
               held++;
            end
         end
         MODE_DELETE: begin
            if (p >= held)
               r.status = STAT_RANGE;
            else begin
               for (k = p; k + 1 < held; k++)
                  cells[k] = cells[k+1];
               held--;
            end
         end
         MODE_READ: begin
            if (p >= held)
               r.status = STAT_RANGE;
            else
               r.read_value = cells[p];
         end
         MODE_WRITE: begin
            if (p >= held)
               r.status = STAT_RANGE;
            else
               cells[p] = v;
         end
         MODE_CLEAR: begin
            held = 0;
         end
         default: begin
         end
      endcase
      r.element_count = held[COUNT_W-1:0];
      return r;
   endfunction

   task automatic note_failure(input string why);
      if (fail_count < 10)
         $display("mismatch at %0t: %s", $time, why);
      fail_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         held = 0;
         fail_count = 0;
         awaited.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0)
               note_failure($sformatf("unexpected word rd=%0h st=%0d cnt=%0d",
                  rsp_read_value, rsp_status, rsp_element_count));
            else begin
               want = awaited.pop_front();
               if (rsp_read_value !== want.read_value || rsp_status !== want.status ||
                   rsp_element_count !== want.element_count)
                  note_failure($sformatf(
                     "exp rd=%0h st=%0d cnt=%0d, got rd=%0h st=%0d cnt=%0d",
                     want.read_value, want.status, want.element_count,
                     rsp_read_value, rsp_status, rsp_element_count));
            end
         end
         if (req_valid && !req_stall)
            awaited.push_back(apply_request(req_mode, req_position, req_value));
      end
      pending = awaited.size();
   end

endmodule

>>> sim/tb_indexed_sequence_store.sv
`timescale 1ns / 100ps
// Testbench top for the indexed sequence store: clock, reset, request and
// stall stimulus, and the verdict. Depends on isq_pkg, the block and sequence_checker.
module tb_indexed_sequence_store;
   import isq_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_WORDS = 800;
   localparam int PHASE_LEN    = 150;
   localparam int RUN_LIMIT    = 400000;
   localparam int LONG_HOLD    = 400;
   localparam logic [MODE_W-1:0] SPARE_MODE_LO  = 3'd5;
   localparam logic [MODE_W-1:0] SPARE_MODE_MID = 3'd6;
   localparam logic [MODE_W-1:0] SPARE_MODE_HI  = 3'd7;
   localparam logic [POS_W-1:0]  POS_MAX        = 7'd127;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode;
   logic [POS_W-1:0]    req_position;
   logic [DATA_W-1:0]   req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [DATA_W-1:0]   rsp_read_value;
   logic [STAT_W-1:0]   rsp_status;
   logic [COUNT_W-1:0]  rsp_element_count;

   int fail_count;
   int pending;
   int words_sent;
   int fill;
   bit no_gaps;

   indexed_sequence_store #(.CAPACITY(CAPACITY)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   sequence_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // fill tracks the element count as the sender sees it, to aim positions
   task automatic send_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
                            input logic [DATA_W-1:0] v);
      int gap;
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_position <= p;
      req_value    <= v;
      do @(posedge clock); while (req_stall);
      words_sent++;
      case (m)
         MODE_INSERT: if (p <= fill && fill < CAPACITY) fill++;
         MODE_DELETE: if (p < fill) fill--;
         MODE_CLEAR:  fill = 0;
         default: ;
      endcase
      if (no_gaps)
         gap = 0;
      else if ($urandom_range(0, 9) < 6)
         gap = 0;
      else if ($urandom_range(0, 9) < 8)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(5, 40);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [MODE_W-1:0] pick_mode(input int phase);
      int r, t_ins, t_del, t_rd, t_wr, t_clr;
      r = $urandom_range(0, 99);
      case (phase)
         0: begin t_ins = 75; t_del = 80; t_rd = 89; t_wr = 98; t_clr = 98; end
         2: begin t_ins = 20; t_del = 70; t_rd = 82; t_wr = 94; t_clr = 96; end
         default: begin t_ins = 35; t_del = 63; t_rd = 80; t_wr = 94; t_clr = 97; end
      endcase
      if (r < t_ins) return MODE_INSERT;
      if (r < t_del) return MODE_DELETE;
      if (r < t_rd)  return MODE_READ;
      if (r < t_wr)  return MODE_WRITE;
      if (r < t_clr) return MODE_CLEAR;
      return MODE_W'($urandom_range(SPARE_MODE_LO, SPARE_MODE_HI));
   endfunction

   function automatic logic [POS_W-1:0] pick_position(input logic [MODE_W-1:0] m);
      if ($urandom_range(0, 99) < 12)
         return POS_W'($urandom_range(0, POS_MAX));
      if (m == MODE_INSERT)
         return POS_W'($urandom_range(0, fill));
      if (fill > 0)
         return POS_W'($urandom_range(0, fill - 1));
      return POS_W'($urandom_range(0, POS_MAX));
   endfunction

   initial begin : sender
      int i;
      int phase;
      logic [MODE_W-1:0] m;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_mode     <= MODE_INSERT;
      req_position <= '0;
      req_value    <= '0;
      words_sent = 0;
      fill = 0;
      no_gaps = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty store, range errors, front/back/middle inserts, front/back removals
      send_word(MODE_READ,   7'd0,    8'h00);
      send_word(MODE_DELETE, 7'd0,    8'hFF);
      send_word(MODE_WRITE,  7'd0,    8'hFF);
      send_word(MODE_INSERT, 7'd1,    8'h11);
      send_word(MODE_CLEAR,  7'd0,    8'h00);
      send_word(MODE_INSERT, 7'd0,    8'hFF);
      send_word(MODE_INSERT, 7'd1,    8'h00);
      send_word(MODE_INSERT, 7'd0,    8'hA5);
      send_word(MODE_INSERT, 7'd1,    8'h5A);
      send_word(MODE_READ,   7'd0,    8'h00);
      send_word(MODE_READ,   7'd1,    8'hFF);
      send_word(MODE_READ,   7'd2,    8'h00);
      send_word(MODE_READ,   7'd3,    8'h00);
      send_word(MODE_WRITE,  7'd3,    8'h3C);
      send_word(MODE_READ,   7'd4,    8'h00);
      send_word(MODE_INSERT, POS_MAX, 8'h81);
      send_word(MODE_DELETE, 7'd3,    8'h00);
      send_word(MODE_DELETE, 7'd0,    8'h00);
      send_word(SPARE_MODE_LO,  POS_MAX, 8'hFF);
      send_word(SPARE_MODE_MID, 7'd64,   8'h00);
      send_word(SPARE_MODE_HI,  POS_MAX, 8'h7F);
      send_word(MODE_DELETE, 7'd64,   8'h00);
      send_word(MODE_READ,   7'd1,    8'h00);
      send_word(MODE_CLEAR,  POS_MAX, 8'hFF);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         phase = (i / PHASE_LEN) % 4;
         no_gaps = (phase == 3);
         m = pick_mode(phase);
         send_word(m, pick_position(m), DATA_W'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (12) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // one long hold-off fills the pipe while the sender keeps offering
   initial begin : receiver
      int hold;
      bit long_done;
      hold = 0;
      long_done = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!long_done && words_sent >= 300) begin
            long_done = 1;
            rsp_stall <= 1'b1;
            hold = LONG_HOLD;
         end else if (hold > 0)
            hold--;
         else if (rsp_stall) begin
            rsp_stall <= 1'b0;
            hold = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(0, 6);
         end else begin
            rsp_stall <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 3);
         end
      end
   end

   initial begin : watchdog
      repeat (RUN_LIMIT) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
